/* rtl/core/video_memory_write_address_map_macros.svh */
// assertion helpers for the video write address map
// both sample on clk and stay quiet while arst_n is low
`ifndef VIDEO_MEMORY_WRITE_ADDRESS_MAP_MACROS_SVH
`define VIDEO_MEMORY_WRITE_ADDRESS_MAP_MACROS_SVH

// consequent checked in the same cycle
`define VMWAM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("video write map check failed");

// consequent checked in the cycle after the antecedent
`define VMWAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("video write map check failed");

`endif

/* rtl/core/vmwam_pkg.sv */
// ----------------------------------------------------------------------------
// vmwam_pkg
// shared constants and stage types of the video write address map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vmwam_pkg;

	localparam logic [15:0] TEXT_LO    = 16'h0400;
	localparam logic [15:0] TEXT_HI    = 16'h0C00;
	localparam logic [15:0] TEXT_PAGE2 = 16'h0800;
	localparam logic [15:0] HGR_LO     = 16'h2000;
	localparam logic [15:0] HGR_HI     = 16'h6000;
	localparam logic [15:0] HGR_PAGE2  = 16'h4000;

	localparam logic [6:0] ROW_BYTES  = 7'd40;
	localparam logic [6:0] TWO_ROWS   = 7'd80;
	localparam logic [6:0] HOLE_START = 7'd120;

	localparam logic REGION_TEXT = 1'b0;
	localparam logic REGION_HGR  = 1'b1;

	// after decode: address split into its interleave fields
	typedef struct packed {
		logic       hit;
		logic       region;
		logic       bank;
		logic       page;
		logic [1:0] group;
		logic [2:0] row_bits;
		logic [2:0] scan;
		logic [5:0] column;
		logic [7:0] data;
	} dec_t;

	// after row assembly: fields already cleared on a miss
	typedef struct packed {
		logic       hit;
		logic       region;
		logic       bank;
		logic       page;
		logic [7:0] row;
		logic [5:0] column;
		logic [7:0] data;
	} row_t;

endpackage

`default_nettype wire

/* rtl/core/vmwam_if.sv */
// ----------------------------------------------------------------------------
// vmwam channel interfaces
// valid/ready channels for the incoming write and the mapped result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vmwam_cmd_if;
	logic        valid;
	logic        ready;
	logic [15:0] cpu_address;
	logic        aux_bank;
	logic [7:0]  write_byte;

	modport source (output valid, output cpu_address, output aux_bank, output write_byte,
		input ready);
	modport sink (input valid, input cpu_address, input aux_bank, input write_byte,
		output ready);
endinterface

interface vmwam_res_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        region;
	logic        bank_out;
	logic        page_out;
	logic [7:0]  screen_row;
	logic [5:0]  screen_column;
	logic [12:0] linear_index;
	logic [7:0]  byte_out;

	modport source (output valid, output hit, output region, output bank_out,
		output page_out, output screen_row, output screen_column, output linear_index,
		output byte_out, input ready);
	modport sink (input valid, input hit, input region, input bank_out,
		input page_out, input screen_row, input screen_column, input linear_index,
		input byte_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/vmwam_decode.sv */
// ----------------------------------------------------------------------------
// vmwam_decode
// first stage: region and page decode, screen hole test, group and column split
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmwam_decode
	import vmwam_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	vmwam_cmd_if.sink  cmd,
	input  wire logic  ready_dn,
	output logic       valid_s1,
	output dec_t       dec_s1
);

	logic       is_text;
	logic       is_hgr;
	logic [6:0] low7;
	logic       ge40;
	logic       ge80;
	logic       hole;
	logic [6:0] col_base;
	logic [6:0] col_full;
	dec_t       dec_d;
	logic       load;

	assign cmd.ready = !valid_s1 || ready_dn;
	assign load      = cmd.valid && cmd.ready;

	always_comb begin
		is_text  = (cmd.cpu_address >= TEXT_LO) && (cmd.cpu_address < TEXT_HI);
		is_hgr   = (cmd.cpu_address >= HGR_LO) && (cmd.cpu_address < HGR_HI);
		low7     = cmd.cpu_address[6:0];
		ge40     = low7 >= ROW_BYTES;
		ge80     = low7 >= TWO_ROWS;
		hole     = low7 >= HOLE_START;
		col_base = ge80 ? TWO_ROWS : (ge40 ? ROW_BYTES : 7'd0);
		col_full = low7 - col_base;

		dec_d          = '0;
		dec_d.hit      = (is_text || is_hgr) && !hole;
		dec_d.region   = is_hgr ? REGION_HGR : REGION_TEXT;
		dec_d.bank     = cmd.aux_bank;
		dec_d.page     = is_hgr ? (cmd.cpu_address >= HGR_PAGE2)
			: (cmd.cpu_address >= TEXT_PAGE2);
		dec_d.group    = ge80 ? 2'd2 : (ge40 ? 2'd1 : 2'd0);
		dec_d.row_bits = cmd.cpu_address[9:7];
		dec_d.scan     = cmd.cpu_address[12:10];
		dec_d.column   = col_full[5:0];
		dec_d.data     = cmd.write_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/vmwam_row.sv */
// ----------------------------------------------------------------------------
// vmwam_row
// second stage: linear row from group, row bits and scanline, miss clearing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmwam_row
	import vmwam_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid_s1,
	input  dec_t      dec_s1,
	output logic      ready_up,
	input  wire logic ready_dn,
	output logic      valid_s2,
	output row_t      row_s2
);

	row_t row_d;

	assign ready_up = !valid_s2 || ready_dn;

	always_comb begin
		row_d = '0;
		if (dec_s1.hit) begin
			row_d.hit    = 1'b1;
			row_d.region = dec_s1.region;
			row_d.bank   = dec_s1.bank;
			row_d.page   = dec_s1.page;
			// text: group*8 + row bits, hi-res: group*64 + row bits*8 + scanline
			if (dec_s1.region == REGION_HGR) begin
				row_d.row = {dec_s1.group, dec_s1.row_bits, dec_s1.scan};
			end else begin
				row_d.row = {3'b000, dec_s1.group, dec_s1.row_bits};
			end
			row_d.column = dec_s1.column;
			row_d.data   = dec_s1.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_up) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_s1) begin
			row_s2 <= row_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/vmwam_index.sv */
// ----------------------------------------------------------------------------
// vmwam_index
// third stage: linear index row*40 + column into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmwam_index
	import vmwam_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  valid_s2,
	input  row_t       row_s2,
	output logic       ready_up,
	vmwam_res_if.source res
);

	logic [12:0] index_d;
	logic        valid_s3;

	// row*40 as row*32 + row*8
	assign index_d = {row_s2.row, 5'b00000} + {2'b00, row_s2.row, 3'b000}
		+ {7'b0000000, row_s2.column};

	assign ready_up  = !valid_s3 || res.ready;
	assign res.valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_up) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_s2) begin
			res.hit           <= row_s2.hit;
			res.region        <= row_s2.region;
			res.bank_out      <= row_s2.bank;
			res.page_out      <= row_s2.page;
			res.screen_row    <= row_s2.row;
			res.screen_column <= row_s2.column;
			res.linear_index  <= index_d;
			res.byte_out      <= row_s2.data;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/video_memory_write_address_map.sv */
// ----------------------------------------------------------------------------
// video_memory_write_address_map
// maps an interleaved screen write address to a linear frame buffer location
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                            role
//   cmd      in   cpu_address, aux_bank, write_byte                  cpu write word
//   res      out  hit, region, bank_out, page_out, screen_row,       mapped word
//                 screen_column, linear_index, byte_out
//
// three register stages (decode, row, index); one word is taken every cycle
// while res drains. each stage holds its word when the one after it is full
// and stalled, so bubbles still fill behind a waiting result. reset clears
// the valid bits only; the pipeline is empty afterwards.
//
`timescale 1ns / 1ps
`default_nettype none

module video_memory_write_address_map
	import vmwam_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	vmwam_cmd_if.sink   cmd,
	vmwam_res_if.source res
);

	logic valid_s1;
	logic valid_s2;
	dec_t dec_s1;
	row_t row_s2;
	logic ready_2;
	logic ready_3;

	vmwam_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.ready_dn (ready_2),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	vmwam_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.ready_up (ready_2),
		.ready_dn (ready_3),
		.valid_s2 (valid_s2),
		.row_s2   (row_s2)
	);

	vmwam_index u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.row_s2   (row_s2),
		.ready_up (ready_3),
		.res      (res)
	);

endmodule

`default_nettype wire

/* rtl/core/vmwam_checker.sv */
// ----------------------------------------------------------------------------
// vmwam_checker
// port level checks on the mapped result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "video_memory_write_address_map_macros.svh"

module vmwam_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic        res_hit,
	input wire logic        res_region,
	input wire logic        res_bank,
	input wire logic        res_page,
	input wire logic [7:0]  res_row,
	input wire logic [5:0]  res_column,
	input wire logic [12:0] res_index,
	input wire logic [7:0]  res_byte
);

	// a stalled result word keeps its index
	`VMWAM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_index))

	// a miss carries nothing
	`VMWAM_ASSERT_NOW(a_miss_clear, res_valid && !res_hit, !res_region && !res_bank && !res_page && res_row == 8'd0 && res_column == 6'd0 && res_index == 13'd0 && res_byte == 8'd0)

	// index agrees with row and column
	`VMWAM_ASSERT_NOW(a_index_sum, res_valid && res_hit, 14'(res_row) * 14'd40 + 14'(res_column) == 14'(res_index))

	// column stays inside the row
	`VMWAM_ASSERT_NOW(a_column_range, res_valid && res_hit, res_column < 6'd40)

	// text rows stop at 24
	`VMWAM_ASSERT_NOW(a_text_rows, res_valid && res_hit && !res_region, res_row < 8'd24)

endmodule

bind video_memory_write_address_map vmwam_checker u_vmwam_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_hit    (res.hit),
	.res_region (res.region),
	.res_bank   (res.bank_out),
	.res_page   (res.page_out),
	.res_row    (res.screen_row),
	.res_column (res.screen_column),
	.res_index  (res.linear_index),
	.res_byte   (res.byte_out)
);

`default_nettype wire

/* test/vmwam_write_checker.sv */
// ----------------------------------------------------------------------------
// vmwam_write_checker
// watches the cpu write and mapped result channels, works out the linear
// frame buffer location of every accepted write and compares it, field by
// field, with the oldest outstanding mapped word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmwam_write_checker
	import vmwam_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	vmwam_cmd_if      cmd,
	vmwam_res_if      res,
	output int        mismatch_count,
	output int        words_in_flight
);

	typedef struct packed {
		logic        hit;
		logic        region;
		logic        bank;
		logic        page;
		logic [7:0]  row;
		logic [5:0]  column;
		logic [12:0] index;
		logic [7:0]  data;
	} mapped_word_t;

	localparam int EXP_DEPTH = 64;

	// ring of predicted words, far deeper than the pipeline
	mapped_word_t expected_words[EXP_DEPTH];
	logic [5:0]   wr_ptr;
	logic [5:0]   rd_ptr;

	// interleaved screen address to linear buffer location
	function automatic mapped_word_t map_write(logic [15:0] addr, logic aux, logic [7:0] data);
		mapped_word_t w;
		logic         in_text;
		logic         in_hgr;
		int           low7;
		int           row;
		int           col;
		w       = '0;
		in_text = (addr >= TEXT_LO) && (addr < TEXT_HI);
		in_hgr  = (addr >= HGR_LO) && (addr < HGR_HI);
		low7    = int'(addr[6:0]);
		// screen holes and addresses outside both pages give an all-zero word
		if ((in_text || in_hgr) && low7 < int'(HOLE_START)) begin
			col = low7 % int'(ROW_BYTES);
			if (in_text) begin
				row = (low7 / int'(ROW_BYTES)) * 8 + int'(addr[9:7]);
			end else begin
				row = (low7 / int'(ROW_BYTES)) * 64 + int'(addr[9:7]) * 8 + int'(addr[12:10]);
			end
			w.hit    = 1'b1;
			w.region = in_text ? REGION_TEXT : REGION_HGR;
			w.bank   = aux;
			w.page   = in_text ? (addr >= TEXT_PAGE2) : (addr >= HGR_PAGE2);
			w.row    = 8'(row);
			w.column = 6'(col);
			w.index  = 13'(row * int'(ROW_BYTES) + col);
			w.data   = data;
		end
		return w;
	endfunction

	task automatic compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	initial begin
		mismatch_count  = 0;
		words_in_flight = 0;
		wr_ptr          = '0;
		rd_ptr          = '0;
	end

	always @(posedge clk) begin
		mapped_word_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (wr_ptr == rd_ptr) begin
					mismatch_count++;
					$display("%0t: mapped word expected none, got index %0d hit %0b",
						$time, res.linear_index, res.hit);
				end else begin
					want   = expected_words[rd_ptr];
					rd_ptr = rd_ptr + 6'd1;
					compare_field("hit", want.hit, res.hit);
					compare_field("region", want.region, res.region);
					compare_field("bank_out", want.bank, res.bank_out);
					compare_field("page_out", want.page, res.page_out);
					compare_field("screen_row", want.row, res.screen_row);
					compare_field("screen_column", want.column, res.screen_column);
					compare_field("linear_index", want.index, res.linear_index);
					compare_field("byte_out", want.data, res.byte_out);
				end
			end
			if (cmd.valid && cmd.ready) begin
				expected_words[wr_ptr] = map_write(cmd.cpu_address, cmd.aux_bank,
					cmd.write_byte);
				wr_ptr = wr_ptr + 6'd1;
			end
		end
		words_in_flight <= int'(6'(wr_ptr - rd_ptr));
	end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives cpu video writes into the address map with random gaps and result
// stalls, a long result hold-off and a full drain, and reports the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import vmwam_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;

	// boundaries, last columns, last rows and screen holes of both pages
	localparam logic [15:0] EDGE_ADDRS [24] = '{
		16'h0000, 16'hFFFF, 16'h03FF, 16'h0400, 16'h07FF, 16'h0800,
		16'h0BFF, 16'h0C00, 16'h0427, 16'h0428, 16'h0477, 16'h0478,
		16'h047F, 16'h07D0, 16'h0BF7, 16'h1FFF, 16'h2000, 16'h2027,
		16'h3FF7, 16'h3FF8, 16'h4000, 16'h5FF7, 16'h5FFF, 16'h6000
	};

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   words_in_flight;
	bit   send_steady  = 1'b0;
	bit   recv_steady  = 1'b0;
	bit   hold_request = 1'b0;
	bit   hold_active  = 1'b0;
	int   recv_stall;

	vmwam_cmd_if cmd ();
	vmwam_res_if res ();

	video_memory_write_address_map dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	vmwam_write_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.res             (res),
		.mismatch_count  (mismatch_count),
		.words_in_flight (words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_gap(bit steady);
		if (steady || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	// mostly inside the two pages, some forced holes, some anywhere
	function automatic logic [15:0] rand_address();
		logic [15:0] a;
		case ($urandom_range(0, 9))
			0, 1, 2: a = 16'($urandom_range(TEXT_LO, TEXT_HI - 1));
			3, 4, 5, 6: a = 16'($urandom_range(HGR_LO, HGR_HI - 1));
			7: begin
				if ($urandom_range(0, 1) == 1) begin
					a = 16'($urandom_range(TEXT_LO, TEXT_HI - 1));
				end else begin
					a = 16'($urandom_range(HGR_LO, HGR_HI - 1));
				end
				a[6:0] = 7'($urandom_range(HOLE_START, 127));
			end
			default: a = 16'($urandom);
		endcase
		return a;
	endfunction

	task automatic send_write(input logic [15:0] addr, input logic aux, input logic [7:0] data);
		int gap;
		gap = draw_gap(send_steady);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.cpu_address <= addr;
		cmd.aux_bank    <= aux;
		cmd.write_byte  <= data;
		do @(posedge clk); while (!cmd.ready);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_write(rand_address(), 1'($urandom_range(0, 1)), 8'($urandom));
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		// wait so the last accepted word is counted in words_in_flight
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
	endtask

	// result side: per-word stall, or held off while a long hold is active
	initial begin
		res.ready <= 1'b0;
		recv_stall = 0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				recv_stall = draw_gap(recv_steady);
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			res.ready <= !hold_active && recv_stall == 0;
		end
	end

	initial begin
		wait (hold_request);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("[video_memory_write_address_map] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd.valid       <= 1'b0;
		cmd.cpu_address <= '0;
		cmd.aux_bank    <= 1'b0;
		cmd.write_byte  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 24; i++) begin
			send_write(EDGE_ADDRS[i], i[1], i[0] ? 8'hFF : 8'h00);
		end
		wait_drained();

		send_random(250);

		// back to back, no idling on either side
		send_steady = 1'b1;
		recv_steady = 1'b1;
		send_random(150);

		// results held off while writes keep coming
		recv_steady  = 1'b0;
		hold_request = 1'b1;
		send_random(120);
		send_steady = 1'b0;
		wait_drained();

		send_random(230);
		wait_drained();
		repeat (6) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("[video_memory_write_address_map] OK");
		end else begin
			$display("[video_memory_write_address_map] ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/vmwam_pkg.sv
rtl/core/vmwam_if.sv
rtl/core/vmwam_decode.sv
rtl/core/vmwam_row.sv
rtl/core/vmwam_index.sv
rtl/core/video_memory_write_address_map.sv
rtl/core/vmwam_checker.sv
test/vmwam_write_checker.sv
test/tb_top.sv
